[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the path table interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever pre holds at a clock edge, post must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

// Whenever pre holds at a clock edge, post must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/pptint_pkg.sv]
// Package with types, constants and state encodings of the path table interpolator.
`default_nettype none

package pptint_pkg;

	// Field widths.
	localparam int VAL_W      = 64;
	localparam int TIME_W     = 62;
	localparam int IDX_W      = 6;
	localparam int CFG_ADDR_W = 2;
	localparam int PROD_W     = VAL_W + TIME_W;

	// Default number of table points.
	localparam int POINTS_DEF = 64;

	// Item kinds.
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT = 2'd2;

	// Input item.
	typedef struct packed {
		logic                    kind;
		logic [IDX_W-1:0]        point_index;
		logic signed [VAL_W-1:0] point_x;
		logic signed [VAL_W-1:0] point_y;
		logic [TIME_W-1:0]       now_ms;
		logic signed [VAL_W-1:0] parent_x;
		logic signed [VAL_W-1:0] parent_y;
	} item_t;

	// Result item.
	typedef struct packed {
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
	} result_t;

	// Configuration write beat.
	typedef struct packed {
		logic [CFG_ADDR_W-1:0] addr;
		logic [TIME_W-1:0]     wdata;
	} cfg_wr_t;

	// Strobes from the sequencer to the interpolation lanes.
	typedef struct packed {
		logic cur_ld;
		logic nxt_ld;
	} lane_ctl_t;

	// Main sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PHASE,
		S_SEG,
		S_RD0,
		S_RD1,
		S_RD2,
		S_LANE,
		S_OUT
	} seq_state_t;

	// Lane states.
	typedef enum logic [2:0] {
		LN_IDLE,
		LN_MAG,
		LN_MUL,
		LN_DIVGO,
		LN_DIV,
		LN_FIN,
		LN_DONE
	} lane_state_t;

endpackage

`default_nettype wire

[hw/rtl/pptint_chan_if.sv]
// Valid/ready channel interface carrying one payload beat.
`default_nettype none

interface pptint_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/periodic_path_table_interpolator.sv]
// An update runs the phase and segment divides, three table reads and the lane steps
// (magnitude, multiply steps, divider start, divide steps and done, finishing), then
// loads the result register, which waits while the last result has not been taken.
// A load beat is written to the table as it is accepted. One update is in flight at a
// time; no item is accepted until it is done. Reset sets period 1, offset 0, segment 1
// and empties the result register; the point table is not cleared.
`default_nettype none
`include "assert_macros.svh"

module periodic_path_table_interpolator #(
	parameter int POINTS = pptint_pkg::POINTS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pptint_chan_if.sink   items,
	pptint_chan_if.source results,
	pptint_chan_if.sink   cfg
);

	localparam int VW    = pptint_pkg::VAL_W;
	localparam int TW    = pptint_pkg::TIME_W;
	localparam int IW    = $clog2(POINTS);
	localparam int PH_DW = TW + 1;
	localparam int PCW   = $clog2(PH_DW + 1);

	pptint_pkg::seq_state_t state_q, state_d;

	logic [TW-1:0]        per_q;
	logic [TW-1:0]        off_q;
	logic [TW-1:0]        seg_q;
	logic [VW-1:0]        parent_x_q;
	logic [VW-1:0]        parent_y_q;
	logic [IW-1:0]        modacc_q;
	logic [IW-1:0]        cur_idx_q;
	logic [TW-1:0]        frac_q;
	logic                 res_valid_q;
	pptint_pkg::result_t  res_data_q;

	logic                 acc_in;
	logic                 acc_update;
	logic                 load_ok;
	logic                 out_free;
	logic [IW-1:0]        nxt_idx;
	logic [IW:0]          fold;
	logic [IW-1:0]        modacc_next;

	logic                 ph_start;
	logic [PH_DW-1:0]     ph_dividend;
	logic [PCW-1:0]       ph_count;
	logic [TW-1:0]        ph_divisor;
	logic                 ph_done;
	logic                 ph_step;
	logic                 ph_qbit;
	logic [TW-1:0]        ph_rem;

	logic [IW-1:0]        raddr;
	logic [VW-1:0]        rdata_x;
	logic [VW-1:0]        rdata_y;
	pptint_pkg::lane_ctl_t lane_ctl;
	logic                 x_done;
	logic                 y_done;
	logic [VW-1:0]        pos_x;
	logic [VW-1:0]        pos_y;

	// Handshake qualifiers.
	always_comb begin
		acc_in     = items.valid && items.ready;
		acc_update = acc_in && (items.data.kind == pptint_pkg::KIND_UPDATE);
		load_ok    = acc_in && (items.data.kind == pptint_pkg::KIND_LOAD)
			&& (32'(items.data.point_index) < 32'(POINTS));
		out_free   = !res_valid_q || results.ready;
		nxt_idx    = (cur_idx_q == IW'(POINTS - 1)) ? '0 : (cur_idx_q + 1'b1);
	end

	// Segment index modulo the point count, folded in as quotient bits arrive.
	always_comb begin
		fold = {modacc_q, ph_qbit};
		if (fold >= (IW + 1)'(POINTS)) begin
			fold = fold - (IW + 1)'(POINTS);
		end
		modacc_next = fold[IW-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pptint_pkg::S_IDLE:  if (acc_update) state_d = pptint_pkg::S_PHASE;
			pptint_pkg::S_PHASE: if (ph_done) state_d = pptint_pkg::S_SEG;
			pptint_pkg::S_SEG:   if (ph_done) state_d = pptint_pkg::S_RD0;
			pptint_pkg::S_RD0:   state_d = pptint_pkg::S_RD1;
			pptint_pkg::S_RD1:   state_d = pptint_pkg::S_RD2;
			pptint_pkg::S_RD2:   state_d = pptint_pkg::S_LANE;
			pptint_pkg::S_LANE:  if (x_done) state_d = pptint_pkg::S_OUT;
			pptint_pkg::S_OUT:   if (out_free) state_d = pptint_pkg::S_IDLE;
			default:             state_d = pptint_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		items.ready     = 1'b0;
		cfg.ready       = 1'b1;
		ph_start        = 1'b0;
		ph_dividend     = {1'b0, items.data.now_ms} + {1'b0, off_q};
		ph_count        = PCW'(PH_DW);
		ph_divisor      = per_q;
		raddr           = cur_idx_q;
		lane_ctl.cur_ld = 1'b0;
		lane_ctl.nxt_ld = 1'b0;
		case (state_q)
			pptint_pkg::S_IDLE: begin
				items.ready = 1'b1;
				ph_start    = acc_update;
			end
			pptint_pkg::S_PHASE: begin
				ph_start    = ph_done;
				ph_dividend = {ph_rem, 1'b0};
				ph_count    = PCW'(PH_DW - 1);
			end
			pptint_pkg::S_SEG: begin
				ph_dividend = {ph_rem, 1'b0};
				ph_count    = PCW'(PH_DW - 1);
				ph_divisor  = seg_q;
			end
			pptint_pkg::S_RD1: begin
				raddr           = nxt_idx;
				lane_ctl.cur_ld = 1'b1;
			end
			pptint_pkg::S_RD2: begin
				raddr           = nxt_idx;
				lane_ctl.nxt_ld = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pptint_pkg::S_IDLE;
			per_q       <= TW'(1);
			off_q       <= '0;
			seg_q       <= TW'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Configuration writes; a zero period or segment acts as one.
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.addr)
					pptint_pkg::REG_PERIOD:
						per_q <= (cfg.data.wdata == '0) ? TW'(1) : cfg.data.wdata;
					pptint_pkg::REG_OFFSET:
						off_q <= cfg.data.wdata;
					pptint_pkg::REG_SEGMENT:
						seg_q <= (cfg.data.wdata == '0) ? TW'(1) : cfg.data.wdata;
					default: ;
				endcase
			end
			// Result register: loaded when the lanes finish, freed when taken.
			if (state_q == pptint_pkg::S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (acc_update) begin
			parent_x_q <= items.data.parent_x;
			parent_y_q <= items.data.parent_y;
		end
		if (state_q == pptint_pkg::S_PHASE && ph_done) begin
			modacc_q <= '0;
		end else if (state_q == pptint_pkg::S_SEG && ph_step) begin
			modacc_q <= modacc_next;
		end
		if (state_q == pptint_pkg::S_SEG && ph_done) begin
			cur_idx_q <= modacc_q;
			frac_q    <= ph_rem;
		end
		if (state_q == pptint_pkg::S_OUT && out_free) begin
			res_data_q.pos_x <= pos_x;
			res_data_q.pos_y <= pos_y;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_data_q;

	// Shared divider for the phase and segment passes.
	pptint_div #(
		.DW(PH_DW),
		.QW(TW)
	) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ph_start),
		.dividend (ph_dividend),
		.count    (ph_count),
		.divisor  (ph_divisor),
		.done     (ph_done),
		.step     (ph_step),
		.qbit     (ph_qbit),
		.quo      (),
		.rem      (ph_rem)
	);

	// Point tables, written by load beats.
	pptint_ram #(
		.WIDTH(VW),
		.DEPTH(POINTS)
	) u_path_x_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (IW'(items.data.point_index)),
		.wdata (items.data.point_x),
		.raddr (raddr),
		.rdata (rdata_x)
	);

	pptint_ram #(
		.WIDTH(VW),
		.DEPTH(POINTS)
	) u_path_y_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (IW'(items.data.point_index)),
		.wdata (items.data.point_y),
		.raddr (raddr),
		.rdata (rdata_y)
	);

	// Interpolation lanes, one per axis.
	pptint_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.rdata  (rdata_x),
		.parent (parent_x_q),
		.frac   (frac_q),
		.seg    (seg_q),
		.done   (x_done),
		.pos    (pos_x)
	);

	pptint_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.rdata  (rdata_y),
		.parent (parent_y_q),
		.frac   (frac_q),
		.seg    (seg_q),
		.done   (y_done),
		.pos    (pos_y)
	);

	// Both lanes run the same schedule and must finish together.
	`ASSERT_IMPLIES(a_lanes_in_step, clk, arst_n, 1'b1, x_done == y_done, "lanes finished apart")
	// The folded segment index stays inside the table.
	`ASSERT_IMPLIES(a_seg_index_range, clk, arst_n, state_q == pptint_pkg::S_SEG, modacc_q <= IW'(POINTS - 1), "segment index beyond table")
	// An accepted update starts the phase pass on the next cycle.
	`ASSERT_NEXT(a_update_starts, clk, arst_n, acc_update, state_q == pptint_pkg::S_PHASE, "update did not start phase pass")

endmodule

`default_nettype wire

[hw/rtl/pptint_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pptint_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/pptint_div.sv]
// Restoring divider that retires one dividend bit per cycle, MSB first.
`default_nettype none

module pptint_div #(
	parameter int DW = 63,
	parameter int QW = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [DW-1:0]                    dividend,
	input  wire logic [$clog2(DW+1)-1:0]          count,
	input  wire logic [pptint_pkg::TIME_W-1:0]    divisor,
	output logic                                  done,
	output logic                                  step,
	output logic                                  qbit,
	output logic      [QW-1:0]                    quo,
	output logic      [pptint_pkg::TIME_W-1:0]    rem
);

	localparam int CW = $clog2(DW + 1);
	localparam int RW = pptint_pkg::TIME_W;

	logic [DW-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;

	// One compare and subtract per cycle.
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	// Control: load the step counter on start, count it down while running, then pulse done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= count;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend, build quotient and remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign step = run_q;
	assign qbit = ge;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[hw/rtl/pptint_lane.sv]
// One interpolation lane: difference, magnitude, split multiply, divide and offset add.
`default_nettype none

module pptint_lane (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pptint_pkg::lane_ctl_t         ctl,
	input  wire logic [pptint_pkg::VAL_W-1:0]  rdata,
	input  wire logic [pptint_pkg::VAL_W-1:0]  parent,
	input  wire logic [pptint_pkg::TIME_W-1:0] frac,
	input  wire logic [pptint_pkg::TIME_W-1:0] seg,
	output logic                               done,
	output logic      [pptint_pkg::VAL_W-1:0]  pos
);

	localparam int VW     = pptint_pkg::VAL_W;
	localparam int TW     = pptint_pkg::TIME_W;
	localparam int PW     = pptint_pkg::PROD_W;
	localparam int HALF   = VW / 2;
	localparam int DCW    = $clog2(PW + 1);
	localparam logic [2:0] MUL_STEPS = 3'd4;

	pptint_pkg::lane_state_t state_q, state_d;

	logic [VW-1:0]     cur_q;
	logic [VW-1:0]     base_q;
	logic [VW-1:0]     diff_q;
	logic              neg_q;
	logic [VW-1:0]     mag_q;
	logic [2:0]        mcnt_q;
	logic [2*HALF-1:0] pp_q;
	logic [PW-1:0]     prod_q;
	logic [VW-1:0]     pos_q;
	logic [HALF-1:0]   a_half;
	logic [HALF-1:0]   b_half;
	logic [1:0]        pm;
	logic [PW-1:0]     pp_ext;
	logic              div_start;
	logic              div_done;
	logic [VW-1:0]     quo;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pptint_pkg::LN_IDLE:  if (ctl.nxt_ld) state_d = pptint_pkg::LN_MAG;
			pptint_pkg::LN_MAG:   state_d = pptint_pkg::LN_MUL;
			pptint_pkg::LN_MUL:   if (mcnt_q == MUL_STEPS) state_d = pptint_pkg::LN_DIVGO;
			pptint_pkg::LN_DIVGO: state_d = pptint_pkg::LN_DIV;
			pptint_pkg::LN_DIV:   if (div_done) state_d = pptint_pkg::LN_FIN;
			pptint_pkg::LN_FIN:   state_d = pptint_pkg::LN_DONE;
			pptint_pkg::LN_DONE:  state_d = pptint_pkg::LN_IDLE;
			default:              state_d = pptint_pkg::LN_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		div_start = 1'b0;
		done      = 1'b0;
		case (state_q)
			pptint_pkg::LN_DIVGO: div_start = 1'b1;
			pptint_pkg::LN_DONE:  done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pptint_pkg::LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Partial product operand selection: step k uses half k[0] of the
	// magnitude and half k[1] of the fraction.
	always_comb begin
		a_half = mcnt_q[0] ? mag_q[VW-1:HALF] : mag_q[HALF-1:0];
		b_half = mcnt_q[1] ? HALF'(frac[TW-1:HALF]) : frac[HALF-1:0];
		pm     = 2'(mcnt_q - 3'd1);
		case (pm)
			2'b00:   pp_ext = PW'(pp_q);
			2'b11:   pp_ext = PW'(pp_q) << (2 * HALF);
			default: pp_ext = PW'(pp_q) << HALF;
		endcase
	end

	// Lane datapath.
	always_ff @(posedge clk) begin
		if (ctl.cur_ld) begin
			cur_q  <= rdata;
			base_q <= rdata + parent;
		end
		if (ctl.nxt_ld) begin
			diff_q <= rdata - cur_q;
		end
		case (state_q)
			pptint_pkg::LN_MAG: begin
				neg_q  <= diff_q[VW-1];
				mag_q  <= diff_q[VW-1] ? (~diff_q + 1'b1) : diff_q;
				prod_q <= '0;
				mcnt_q <= '0;
			end
			pptint_pkg::LN_MUL: begin
				if (mcnt_q != MUL_STEPS) begin
					pp_q <= a_half * b_half;
				end
				if (mcnt_q != 3'd0) begin
					prod_q <= prod_q + pp_ext;
				end
				mcnt_q <= mcnt_q + 1'b1;
			end
			pptint_pkg::LN_FIN: begin
				pos_q <= neg_q ? (base_q - quo) : (base_q + quo);
			end
			default: ;
		endcase
	end

	// Wide product over the segment length.
	pptint_div #(
		.DW(PW),
		.QW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.count    (DCW'(PW)),
		.divisor  (seg),
		.done     (div_done),
		.step     (),
		.qbit     (),
		.quo      (quo),
		.rem      ()
	);

	assign pos = pos_q;

endmodule

`default_nettype wire

[tb/periodic_path_table_interpolator_test.sv]
// Testbench for the periodic path table interpolator: load and update beats against a position predictor.
module periodic_path_table_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pptint_pkg::*;

	localparam int POINTS = POINTS_DEF;
	// Drain time after the last result; this also covers a load still in flight.
	localparam int DRAIN_CYCLES = 300;
	localparam int unsigned RUN_LIMIT = 1_500_000;
	// Index past the last register; writes to it must change nothing.
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [VAL_W-1:0] COORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] COORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycle_count = 0;
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Predictor copy of the point table and the registers.
	logic [VAL_W-1:0] path_x_mem [POINTS];
	logic [VAL_W-1:0] path_y_mem [POINTS];
	logic [TIME_W-1:0] period_reg = 1;
	logic [TIME_W-1:0] offset_reg = 0;
	logic [TIME_W-1:0] segment_reg = 1;
	result_t pending_positions [$];

	pptint_chan_if #(.payload_t(item_t)) items_ch ();
	pptint_chan_if #(.payload_t(result_t)) results_ch ();
	pptint_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	periodic_path_table_interpolator #(.POINTS(POINTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	// Result side back-pressure.
	always @(posedge clk) begin
		results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every accepted result beat with the oldest predicted position.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			if (pending_positions.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual x %h y %h",
					$time, results_ch.data.pos_x, results_ch.data.pos_y);
				error_count++;
			end else begin
				want = pending_positions.pop_front();
				if (results_ch.data.pos_x !== want.pos_x) begin
					$display("%0t: pos_x mismatch, expected %h, actual %h",
						$time, want.pos_x, results_ch.data.pos_x);
					error_count++;
				end
				if (results_ch.data.pos_y !== want.pos_y) begin
					$display("%0t: pos_y mismatch, expected %h, actual %h",
						$time, want.pos_y, results_ch.data.pos_y);
					error_count++;
				end
			end
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Coordinates lean toward the two's complement extremes now and then.
	function automatic logic [VAL_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return '1;
			default: return rand_word();
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return TIME_MAX;
			2: return $urandom_range(999);
			default: return w[TIME_W-1:0];
		endcase
	endfunction

	// Fields that the kind does not use carry random values.
	function automatic item_t make_load(input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py);
		item_t beat;
		beat.kind = KIND_LOAD;
		beat.point_index = idx;
		beat.point_x = px;
		beat.point_y = py;
		beat.now_ms = rand_time();
		beat.parent_x = rand_word();
		beat.parent_y = rand_word();
		return beat;
	endfunction

	function automatic item_t make_update(input logic [TIME_W-1:0] now,
			input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py);
		item_t beat;
		beat.kind = KIND_UPDATE;
		beat.point_index = $urandom_range(POINTS - 1);
		beat.point_x = rand_word();
		beat.point_y = rand_word();
		beat.now_ms = now;
		beat.parent_x = px;
		beat.parent_y = py;
		return beat;
	endfunction

	// Signed difference times fraction over segment, truncated toward zero.
	function automatic logic [VAL_W-1:0] scaled_step(input logic [VAL_W-1:0] diff,
			input logic [63:0] frac, input logic [63:0] seg);
		logic neg;
		logic [63:0] mag;
		logic [63:0] quot;
		logic [127:0] prod;
		neg = diff[VAL_W-1];
		mag = neg ? -diff : diff;
		prod = {64'b0, mag} * {64'b0, frac};
		prod = prod / {64'b0, seg};
		quot = prod[63:0];
		return neg ? -quot : quot;
	endfunction

	function automatic result_t predict_position(input item_t beat);
		logic [63:0] per;
		logic [63:0] seg;
		logic [63:0] phase;
		logic [63:0] seg_idx;
		logic [63:0] frac;
		int unsigned cur_i;
		int unsigned nxt_i;
		result_t pos;
		per = (period_reg == 0) ? 64'd1 : {2'b0, period_reg};
		seg = (segment_reg == 0) ? 64'd1 : {2'b0, segment_reg};
		phase = ({2'b0, beat.now_ms} + {2'b0, offset_reg}) % per;
		seg_idx = (phase / seg) % POINTS;
		frac = phase % seg;
		cur_i = seg_idx;
		nxt_i = (cur_i + 1) % POINTS;
		pos.pos_x = scaled_step(path_x_mem[nxt_i] - path_x_mem[cur_i], frac, seg)
			+ path_x_mem[cur_i] + beat.parent_x;
		pos.pos_y = scaled_step(path_y_mem[nxt_i] - path_y_mem[cur_i], frac, seg)
			+ path_y_mem[cur_i] + beat.parent_y;
		return pos;
	endfunction

	// Apply an accepted item beat to the predictor.
	function automatic void track_item(input item_t beat);
		if (beat.kind == KIND_LOAD) begin
			if (beat.point_index < POINTS) begin
				path_x_mem[beat.point_index] = beat.point_x;
				path_y_mem[beat.point_index] = beat.point_y;
			end
		end else begin
			pending_positions.push_back(predict_position(beat));
		end
	endfunction

	// Send one item beat, with random idle cycles ahead of it.
	task automatic send_item(input item_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data <= beat;
		@(posedge clk);
		while (items_ch.ready !== 1'b1) @(posedge clk);
		track_item(beat);
	endtask

	// Let every outstanding result drain, then give a load time to settle.
	task automatic wait_quiet();
		items_ch.valid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] value);
		cfg_wr_t wr;
		wr.addr = addr;
		wr.wdata = value;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= wr;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (addr)
			REG_PERIOD: period_reg = value;
			REG_OFFSET: offset_reg = value;
			REG_SEGMENT: segment_reg = value;
			default: ;
		endcase
	endtask

	// Program all registers once the block is idle; the unused index gets junk.
	task automatic configure(input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] off,
			input logic [TIME_W-1:0] seg);
		wait_quiet();
		write_reg(REG_UNUSED, rand_time());
		write_reg(REG_PERIOD, per);
		write_reg(REG_OFFSET, off);
		write_reg(REG_SEGMENT, seg);
		cfg_ch.valid <= 1'b0;
	endtask

	// Every entry is written before any update can read it.
	task automatic test_table_fill();
		for (int i = 0; i < POINTS; i++) begin
			send_item(make_load(i, rand_coord(), rand_coord()));
		end
	endtask

	// With reset registers the phase is always zero.
	task automatic test_reset_config();
		send_item(make_update(TIME_MAX, COORD_MAX, COORD_MIN));
		send_item(make_update('0, '0, '0));
	endtask

	// Largest differences, both fraction ends and the wrap from the last entry.
	task automatic test_interpolation_extremes();
		configure(POINTS * 1000, '0, 1000);
		send_item(make_load(0, '0, '0));
		send_item(make_load(1, COORD_MIN, COORD_MAX));
		send_item(make_load(62, COORD_MAX, COORD_MIN));
		send_item(make_load(POINTS - 1, COORD_MIN, COORD_MAX));
		send_item(make_update(999, COORD_MAX, COORD_MIN));
		send_item(make_update('0, COORD_MIN, COORD_MAX));
		send_item(make_update(1001, rand_coord(), rand_coord()));
		send_item(make_update(62 * 1000 + 500, rand_coord(), rand_coord()));
		send_item(make_update((POINTS - 1) * 1000 + 999, COORD_MIN, COORD_MAX));
		send_item(make_update(TIME_MAX, rand_coord(), rand_coord()));
	endtask

	// Zero period and zero segment both behave as one.
	task automatic test_zero_registers();
		configure('0, TIME_MAX, '0);
		send_item(make_update(TIME_MAX, COORD_MAX, COORD_MAX));
		send_item(make_update(123456789, COORD_MIN, COORD_MIN));
	endtask

	// Periods that are no multiple of the table make the index wrap.
	task automatic test_segment_overrun();
		configure(TIME_MAX, TIME_MAX, 3);
		send_item(make_update(TIME_MAX, rand_coord(), rand_coord()));
		send_item(make_update('0, rand_coord(), rand_coord()));
		send_item(make_update(rand_time(), rand_coord(), rand_coord()));
		configure(1000, '0, 10);
		send_item(make_update(999, rand_coord(), rand_coord()));
		send_item(make_update(700, rand_coord(), rand_coord()));
	endtask

	// Random mix of table loads and position updates.
	task automatic run_random_items(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 35) begin
				send_item(make_load($urandom_range(POINTS - 1), rand_coord(), rand_coord()));
			end else begin
				send_item(make_update(rand_time(), rand_coord(), rand_coord()));
			end
		end
	endtask

	task automatic test_random_no_idle();
		logic [TIME_W-1:0] seg;
		seg = $urandom_range(1, 5000);
		configure(POINTS * seg, rand_time(), seg);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_items(270);
	endtask

	task automatic test_random_sender_idle();
		configure(rand_time(), TIME_MAX, $urandom_range(1, 1000));
		send_idle_pct = 79;
		recv_stall_pct = 0;
		run_random_items(270);
	endtask

	task automatic test_random_receiver_stall();
		configure(rand_time(), rand_time(), rand_time() >> $urandom_range(61, 0));
		send_idle_pct = 0;
		recv_stall_pct = 79;
		run_random_items(270);
	endtask

	task automatic test_random_both_idle();
		configure($urandom_range(1, 300), $urandom_range(0, 1000), $urandom_range(1, 7));
		send_idle_pct = 37;
		recv_stall_pct = 37;
		run_random_items(270);
	endtask

	initial begin
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		results_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_reset_config();
		test_interpolation_extremes();
		test_zero_registers();
		test_segment_overrun();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();

		wait_quiet();
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
